// ===== rtl/custom_order_sortedness_check_core_defines.svh =====
// ----------------------------------------------------------------------------
// Sortedness check assertion macros
// Assertion helpers shared by the sortedness check RTL.
// ----------------------------------------------------------------------------
`ifndef CUSTOM_ORDER_SORTEDNESS_CHECK_CORE_DEFINES_SVH
`define CUSTOM_ORDER_SORTEDNESS_CHECK_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define COSC_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define COSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define COSC_ASSERT(label, clk, rst, ante, cons)
`define COSC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/cosc_pkg.sv =====
// ----------------------------------------------------------------------------
// Sortedness check package
// Types and constants shared by the sortedness check modules.
// ----------------------------------------------------------------------------
package cosc_pkg;

  localparam int LETTER_W  = 5;
  localparam int RANK_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 64;
  localparam int REG_COUNT = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RANK_0_7   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANK_8_15  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANK_16_23 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANK_24_31 = 2'd3;

  // byte k of register i is the rank of letter 8*i+k
  localparam logic [REG_COUNT-1:0][7:0][RANK_W-1:0] RANK_RESET = {
    64'h1F1E1D1C1B1A1918,
    64'h1716151413121110,
    64'h0F0E0D0C0B0A0908,
    64'h0706050403020100
  };

  typedef enum logic [1:0] {
    DEC_UNDECIDED = 2'd0,
    DEC_LESS      = 2'd1,
    DEC_GREATER   = 2'd2
  } dec_t;

  // one letter after the position stage
  typedef struct packed {
    logic              cmp_en;     // previous word has a letter at this place
    logic              end_word;   // word ends here (list end included)
    logic              end_list;
    logic              first;      // letter belongs to the first word
    logic              short_word; // word shorter than the previous one so far
    logic              overflow;   // running truncation flag including this letter
    logic [RANK_W-1:0] rank;
  } item_t;

endpackage

// ===== rtl/cosc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data (read-first).
// ----------------------------------------------------------------------------
module cosc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/cosc_rank_regs.sv =====
// ----------------------------------------------------------------------------
// Rank registers
// Holds the alphabet ranking and looks up the rank of one letter.
// ----------------------------------------------------------------------------
module cosc_rank_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cosc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cosc_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [cosc_pkg::LETTER_W-1:0]  letter,
  output logic [cosc_pkg::RANK_W-1:0]    rank
);

  logic [cosc_pkg::REG_COUNT-1:0][7:0][cosc_pkg::RANK_W-1:0] slots;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots <= cosc_pkg::RANK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cosc_pkg::REG_RANK_0_7:   slots[0] <= cfg_wdata;
        cosc_pkg::REG_RANK_8_15:  slots[1] <= cfg_wdata;
        cosc_pkg::REG_RANK_16_23: slots[2] <= cfg_wdata;
        cosc_pkg::REG_RANK_24_31: slots[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign rank = slots[letter[4:3]][letter[2:0]];

endmodule

// ===== rtl/cosc_front.sv =====
// ----------------------------------------------------------------------------
// Position stage
// Tracks letter position, previous length and word flags, and writes the
// current rank into the word buffer.
// ----------------------------------------------------------------------------
module cosc_front #(
  parameter int MAX_WORD_LEN = 32,
  localparam int POS_W  = $clog2(MAX_WORD_LEN + 1),
  localparam int ADDR_W = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  logic                       end_word,
  input  logic                       end_list,
  input  logic [cosc_pkg::RANK_W-1:0] rank,
  output logic                       buf_we,
  output logic [ADDR_W-1:0]          buf_addr,
  output cosc_pkg::item_t            item
);

  logic [POS_W-1:0] letter_position;
  logic [POS_W-1:0] previous_length;
  logic             first_word;
  logic             overflow;

  logic             pos_ok;
  logic [POS_W-1:0] pos_after;
  logic             ending;

  always_comb begin
    pos_ok    = letter_position < POS_W'(MAX_WORD_LEN);
    pos_after = pos_ok ? letter_position + POS_W'(1) : letter_position;
    ending    = end_word | end_list;

    item.cmp_en     = !first_word && pos_ok && (letter_position < previous_length);
    item.end_word   = ending;
    item.end_list   = end_list;
    item.first      = first_word;
    item.short_word = pos_after < previous_length;
    item.overflow   = overflow | !pos_ok;
    item.rank       = rank;

    buf_we   = fire && pos_ok;
    buf_addr = letter_position[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      letter_position <= '0;
      previous_length <= '0;
      first_word      <= 1'b1;
      overflow        <= 1'b0;
    end else if (fire) begin
      if (end_list) begin
        letter_position <= '0;
        previous_length <= '0;
        first_word      <= 1'b1;
        overflow        <= 1'b0;
      end else if (ending) begin
        letter_position <= '0;
        previous_length <= pos_after;
        first_word      <= 1'b0;
        overflow        <= item.overflow;
      end else begin
        letter_position <= pos_after;
        overflow        <= item.overflow;
      end
    end
  end

endmodule

// ===== rtl/cosc_judge.sv =====
// ----------------------------------------------------------------------------
// Compare stage
// Compares each rank with the buffered previous rank, keeps the word decision
// and the list verdict, and holds the result register.
// ----------------------------------------------------------------------------
module cosc_judge (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  cosc_pkg::item_t             in_item,
  input  logic [cosc_pkg::RANK_W-1:0] prev_rank,
  output logic                        stage_valid,
  output cosc_pkg::item_t             stage_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_in_order,
  output logic                        out_too_long
);

  cosc_pkg::dec_t decision;
  cosc_pkg::dec_t decision_now;
  logic           list_ok;
  logic           list_ok_next;
  logic           stage_fire;

  assign stage_fire = stage_valid && (!stage_item.end_list || !out_valid || out_ready);
  assign in_ready   = !stage_valid || stage_fire;

  always_comb begin
    decision_now = decision;
    if (stage_item.cmp_en && decision == cosc_pkg::DEC_UNDECIDED) begin
      if (prev_rank > stage_item.rank) begin
        decision_now = cosc_pkg::DEC_GREATER;
      end else if (prev_rank < stage_item.rank) begin
        decision_now = cosc_pkg::DEC_LESS;
      end
    end

    list_ok_next = list_ok;
    // a word that stops inside the previous one is out of order too
    if (stage_item.end_word && !stage_item.first &&
        (decision_now == cosc_pkg::DEC_GREATER ||
         (decision_now == cosc_pkg::DEC_UNDECIDED && stage_item.short_word))) begin
      list_ok_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decision <= cosc_pkg::DEC_UNDECIDED;
      list_ok  <= 1'b1;
    end else if (stage_fire) begin
      decision <= stage_item.end_word ? cosc_pkg::DEC_UNDECIDED : decision_now;
      list_ok  <= stage_item.end_list ? 1'b1 : list_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_fire && stage_item.end_list) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire && stage_item.end_list) begin
      out_in_order <= list_ok_next;
      out_too_long <= stage_item.overflow;
    end
  end

endmodule

// ===== rtl/custom_order_sortedness_check_core.sv =====
// ----------------------------------------------------------------------------
// Custom-order sortedness check
// Checks that a streamed list of words is in order under a programmable
// alphabet ranking and reports one verdict per list.
// ----------------------------------------------------------------------------
// Letters stream in one per item, one item per clock unless a stalled output
// holds back a list end. Each letter does a rank lookup and a read and write
// of the word buffer at the accept edge, then one rank compare in the next
// stage; that single buffer access per letter sets the rate. A list's verdict
// is registered in the compare stage and waits in the output register while
// the input keeps flowing. The rank registers must be written only while the
// block is idle (not enforced); no clearing pass is needed after reset.
`include "custom_order_sortedness_check_core_defines.svh"

module custom_order_sortedness_check_core #(
  parameter int MAX_WORD_LEN = 32
) (
  input  logic        clk,
  input  logic        rst,
  // config
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  // letters
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [4:0] letter, [7:5] zero
  input  logic        s_axis_tlast,   // last_of_word
  input  logic        s_axis_tuser,   // last_of_list
  // verdicts
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [0] in_order, [1] word_too_long, [7:2] zero
);

  localparam int ADDR_W = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;

  logic                        s_fire;
  logic [cosc_pkg::RANK_W-1:0] rank;
  logic [cosc_pkg::RANK_W-1:0] prev_rank;
  logic                        buf_we;
  logic [ADDR_W-1:0]           buf_addr;
  cosc_pkg::item_t             item;
  logic                        stage_valid;
  cosc_pkg::item_t             stage_item;
  logic                        in_order;
  logic                        too_long;

  assign s_fire = s_axis_tvalid && s_axis_tready;

  cosc_rank_regs u_rank_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .letter    (s_axis_tdata[cosc_pkg::LETTER_W-1:0]),
    .rank      (rank)
  );

  cosc_front #(
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .fire     (s_fire),
    .end_word (s_axis_tlast),
    .end_list (s_axis_tuser),
    .rank     (rank),
    .buf_we   (buf_we),
    .buf_addr (buf_addr),
    .item     (item)
  );

  // read-first: the old rank at this place comes out while the new one goes in
  cosc_ram #(
    .WIDTH (cosc_pkg::RANK_W),
    .DEPTH (MAX_WORD_LEN)
  ) u_word_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_addr),
    .wdata (rank),
    .re    (s_fire),
    .raddr (buf_addr),
    .rdata (prev_rank)
  );

  cosc_judge u_judge (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_item      (item),
    .prev_rank    (prev_rank),
    .stage_valid  (stage_valid),
    .stage_item   (stage_item),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_in_order (in_order),
    .out_too_long (too_long)
  );

  assign m_axis_tdata = {6'b0, too_long, in_order};

  // a verdict only follows a list end in the compare stage
  `COSC_ASSERT_NEXT(a_result_from_list_end, clk, rst, !(stage_valid && stage_item.end_list) && !(m_axis_tvalid && !m_axis_tready), !m_axis_tvalid)
  // an accepted list end lands in the compare stage
  `COSC_ASSERT_NEXT(a_list_end_staged, clk, rst, s_fire && s_axis_tuser, stage_valid && stage_item.end_list && stage_item.end_word)
  // the first word of a list never compares against the buffer
  `COSC_ASSERT(a_first_word_no_compare, clk, rst, stage_valid && stage_item.first, !stage_item.cmp_en)

endmodule
